// ----- design/per_bit_change_lockout_qualifier_top_macros.svh -----
// assertion macros for the per-bit change lockout qualifier
// used by per_bit_change_lockout_qualifier_top; no other dependencies
`ifndef PER_BIT_CHANGE_LOCKOUT_QUALIFIER_TOP_MACROS_SVH
`define PER_BIT_CHANGE_LOCKOUT_QUALIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check on the rising clock, off while reset is asserted
`define PBCLQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check that also holds during reset
`define PBCLQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBCLQ_ASSERT(label, clk, rst_n, prop, msg)
`define PBCLQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- design/pbclq_pkg.sv -----
// shared constants for the per-bit change lockout qualifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pbclq_pkg;

  // channel count default and field widths
  localparam int unsigned ChannelsDefault = 8;
  localparam int unsigned SampleW         = 8;
  localparam int unsigned ReportW         = 8;
  localparam int unsigned HoldW           = 16;

  // stream word widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 2 * ReportW;

  // hold limit after reset and counter ceiling
  localparam logic [HoldW-1:0] HoldLimitReset = 16'd1500;
  localparam logic [HoldW-1:0] HoldMax        = '1;

endpackage

`default_nettype wire

// ----- design/per_bit_change_lockout_qualifier_top.sv -----
// Per-bit change lockout qualifier: a channel whose sample bit changes passes
// the new value at once, then ignores further changes for the next hold_limit
// valid words and takes the current sample bit again on the word after that.
// With hold_limit at its largest value a locked channel stays locked until
// reset. A word with tuser low is an idle tick: the result has qualified at
// zero and the state holds. One word is accepted every cycle while s_axis_tready
// is high. Each word passes an input register, then the per-channel update into
// the result register. s_axis_tready drops only while a result waits on a low
// m_axis_tready with the input register full. The user writes hold_limit through
// the cfg channel only while idle; the block itself does not enforce this.
// Depends on pbclq_pkg and per_bit_change_lockout_qualifier_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "per_bit_change_lockout_qualifier_top_macros.svh"

module per_bit_change_lockout_qualifier_top #(
  parameter int unsigned CHANNELS = pbclq_pkg::ChannelsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input words
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [pbclq_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] sample
  input  wire logic [pbclq_pkg::InUserW-1:0]   s_axis_tuser,  // [0] sample_valid
  // result words
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [pbclq_pkg::OutDataW-1:0]  m_axis_tdata,  // [7:0] qualified,
                                                              // [15:8] locked_mask
  // hold limit write
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [pbclq_pkg::HoldW-1:0]     cfg_data_i
);

  localparam int unsigned HoldW   = pbclq_pkg::HoldW;
  localparam int unsigned ReportW = pbclq_pkg::ReportW;

  // input stage
  logic                            in_valid_q;
  logic [pbclq_pkg::InDataW-1:0]   in_data_q;
  logic                            in_user_q;
  logic                            advance;

  // result stage
  logic                            out_valid_q;
  logic [pbclq_pkg::OutDataW-1:0]  out_data_q, out_data_d;

  // channel state
  logic [HoldW-1:0]    hold_limit_q;
  logic [CHANNELS-1:0] prev_q, out_q, lock_q;
  logic [CHANNELS-1:0] prev_d, out_d, lock_d;
  logic [HoldW-1:0]    cnt_q [CHANNELS];
  logic [HoldW-1:0]    cnt_d [CHANNELS];
  logic [CHANNELS-1:0] cur;
  logic [CHANNELS-1:0] cnt_nz;
  logic [ReportW-1:0]  out_rep, lock_rep;

  // handshakes
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser[0];
    end
  end

  // sample bit per channel, channels past the sample width read zero
  for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_cur
    if (gi < pbclq_pkg::SampleW) begin : g_in
      assign cur[gi] = in_data_q[gi];
    end else begin : g_zero
      assign cur[gi] = 1'b0;
    end
  end

  // per-channel change detection, lockout and hold counting
  always_comb begin
    logic fresh;
    logic lk;
    logic o;
    prev_d = prev_q;
    out_d  = out_q;
    lock_d = lock_q;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    for (int i = 0; i < CHANNELS; i++) begin
      fresh = (cur[i] ^ prev_q[i]) & ~lock_q[i];
      lk    = lock_q[i] | fresh;
      o     = fresh ? cur[i] : out_q[i];
      if (lk) begin
        if (cnt_q[i] > hold_limit_q) begin
          cnt_d[i] = '0;
          lk       = 1'b0;
          o        = cur[i];
        end else if (cnt_q[i] != pbclq_pkg::HoldMax) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
        end
      end
      lock_d[i] = lk;
      out_d[i]  = o;
    end
    if (in_user_q) begin
      prev_d = cur;
    end else begin
      out_d  = out_q;
      lock_d = lock_q;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_d[i] = cnt_q[i];
      end
    end
  end

  // reported low bits, channels not present read zero
  for (genvar gj = 0; gj < ReportW; gj++) begin : g_rep
    if (gj < CHANNELS) begin : g_ch
      assign out_rep[gj]  = out_d[gj];
      assign lock_rep[gj] = lock_d[gj];
    end else begin : g_none
      assign out_rep[gj]  = 1'b0;
      assign lock_rep[gj] = 1'b0;
    end
  end

  assign out_data_d = {lock_rep, (in_user_q ? out_rep : {ReportW{1'b0}})};

  // channel state and hold limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_limit_q <= pbclq_pkg::HoldLimitReset;
      prev_q       <= '0;
      out_q        <= '0;
      lock_q       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        hold_limit_q <= cfg_data_i;
      end
      if (advance) begin
        prev_q <= prev_d;
        out_q  <= out_d;
        lock_q <= lock_d;
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // nonzero counters for checking
  for (genvar gk = 0; gk < CHANNELS; gk++) begin : g_nz
    assign cnt_nz[gk] = |cnt_q[gk];
  end

  // checks
  `PBCLQ_ASSERT(a_idle_counter_zero, clk_i, rst_ni, (cnt_nz & ~lock_q) == '0,
                "counter running on an unlocked channel")
  `PBCLQ_ASSERT(a_idle_tick_zero, clk_i, rst_ni,
                advance && !in_user_q |=> m_axis_tdata[ReportW-1:0] == '0,
                "idle tick gave a nonzero qualified word")
  `PBCLQ_ASSERT(a_mask_matches_lock, clk_i, rst_ni,
                advance |=> m_axis_tdata[2*ReportW-1:ReportW] == $past(lock_rep),
                "reported lock mask differs from lock state")
  `PBCLQ_ASSERT(a_prev_follows, clk_i, rst_ni,
                advance && in_user_q |=> prev_q == $past(cur),
                "previous sample did not follow a valid word")

endmodule

`default_nettype wire
